// File: src/fvbc_pkg.sv
// Shared types, codes and constants for the view frustum box culling block.
// Used by fvbc_cell, fvbc_extract and view_frustum_box_culling; no dependencies.
package fvbc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int ACC_W      = 66;  // sum of four 64-bit products
  localparam int SUM_W      = 98;  // plane sum over one box corner

  typedef enum logic [2:0] {
    OP_WR_VIEW = 3'd0,
    OP_WR_PROJ = 3'd1,
    OP_EXTRACT = 3'd2,
    OP_POINT   = 3'd3,
    OP_BOX     = 3'd4
  } op_t;

  localparam logic [1:0] VIS_NONE = 2'd0;
  localparam logic [1:0] VIS_PART = 2'd1;
  localparam logic [1:0] VIS_FULL = 2'd2;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // One item as it travels down the row of plane cells.
  typedef struct packed {
    logic             valid;
    logic             is_test;
    logic             is_box;
    logic             culled;
    logic             partial;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
  } token_t;

  // Coefficient write strobe broadcast to all cells.
  typedef struct packed {
    logic       we;
    logic [1:0] idx;
  } coef_wr_t;

  // Clip column that each plane combines with column 3.
  function automatic logic [1:0] plane_col(input int p);
    logic [1:0] c;
    case (p)
      0, 1:    c = 2'd0;
      2, 3:    c = 2'd1;
      default: c = 2'd2;
    endcase
    return c;
  endfunction

  // Planes that subtract the column instead of adding it.
  function automatic logic plane_sub(input int p);
    logic s;
    case (p)
      0, 3, 4: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// File: src/fvbc_cell.sv
// One plane cell: holds a plane's four Q32.32 coefficients and tests each item.
// Depends on fvbc_pkg; items pass through three register stages to the next cell.
module fvbc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     skip_box,
  input  fvbc_pkg::coef_wr_t       coef_wr,
  input  logic [63:0]              coef_data,
  input  fvbc_pkg::token_t         tok_i,
  output fvbc_pkg::token_t         tok_o,
  output logic                     test_busy
);
  import fvbc_pkg::*;

  logic [3:0][63:0]       coef_r;
  token_t                 t1_r, t2_r, t3_r;
  logic [2:0][63:0]       plh_r, phh_r;
  logic [2:0][64:0]       pll_r, phl_r;
  logic [63:0]            d1_r;
  logic [2:0][SUM_W-1:0]  mn_r, mx_r;
  logic [SUM_W-1:0]       d2_r;
  logic [2:0][SUM_W-1:0]  prod_lo, prod_hi;
  logic [SUM_W-1:0]       smin, smax;
  logic                   pos_min, pos_max, active;
  token_t                 t3_nxt;

  // Coefficient store, loaded by the plane extraction sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (coef_wr.we) begin
      coef_r[coef_wr.idx] <= coef_data;
    end
  end

  // Stage 1: split each 64 by 32 product into two partial products, one per 32-bit coefficient half.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
    end else if (adv) begin
      t1_r <= tok_i;
      d1_r <= coef_r[3];
      for (int a = 0; a < 3; a++) begin
        plh_r[a] <= 64'($signed(coef_r[a][63:32]) * $signed(tok_i.lo[a]));
        phh_r[a] <= 64'($signed(coef_r[a][63:32]) * $signed(tok_i.hi[a]));
        pll_r[a] <= 65'($signed({1'b0, coef_r[a][31:0]}) * $signed(tok_i.lo[a]));
        phl_r[a] <= 65'($signed({1'b0, coef_r[a][31:0]}) * $signed(tok_i.hi[a]));
      end
    end
  end

  // Stage 2: recombine the products and order each axis term.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_lo[a] = {{2{plh_r[a][63]}}, plh_r[a], 32'd0} + {{33{pll_r[a][64]}}, pll_r[a]};
      prod_hi[a] = {{2{phh_r[a][63]}}, phh_r[a], 32'd0} + {{33{phl_r[a][64]}}, phl_r[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_r <= '0;
    end else if (adv) begin
      t2_r <= t1_r;
      d2_r <= {{18{d1_r[63]}}, d1_r, 16'd0};
      for (int a = 0; a < 3; a++) begin
        if ($signed(prod_lo[a]) < $signed(prod_hi[a])) begin
          mn_r[a] <= prod_lo[a];
          mx_r[a] <= prod_hi[a];
        end else begin
          mn_r[a] <= prod_hi[a];
          mx_r[a] <= prod_lo[a];
        end
      end
    end
  end

  // Stage 3: extreme plane sums and their signs update the item's flags.
  always_comb begin
    smin    = d2_r + mn_r[0] + mn_r[1] + mn_r[2];
    smax    = d2_r + mx_r[0] + mx_r[1] + mx_r[2];
    pos_min = !smin[SUM_W-1] && (|smin);
    pos_max = !smax[SUM_W-1] && (|smax);
    active  = t2_r.is_test && !(skip_box && t2_r.is_box);
    t3_nxt  = t2_r;
    if (active) begin
      if (!pos_max) begin
        t3_nxt.culled = 1'b1;
      end
      if (!pos_min) begin
        t3_nxt.partial = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_r <= '0;
    end else if (adv) begin
      t3_r <= t3_nxt;
    end
  end

  assign tok_o     = t3_r;
  assign test_busy = (t1_r.valid && t1_r.is_test) || (t2_r.valid && t2_r.is_test) ||
                     (t3_r.valid && t3_r.is_test);

endmodule

// File: src/fvbc_extract.sv
// View and projection matrix store and the plane extraction sequencer.
// Depends on fvbc_pkg; drives the coefficient write bus of the plane cells.
module fvbc_extract (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          wr_view,
  input  logic                                          wr_proj,
  input  logic [3:0]                                    wr_idx,
  input  logic [31:0]                                   wr_data,
  input  logic                                          start,
  output logic                                          busy,
  output fvbc_pkg::coef_wr_t                            coef_wr,
  output logic [fvbc_pkg::NUM_PLANES-1:0][63:0]         coef_data
);
  import fvbc_pkg::*;

  logic [15:0][31:0]      view_r;
  logic [3:0][3:0][31:0]  proj_r;
  seq_state_t             state_r, state_nxt;
  logic [4:0]             cnt_r;
  logic                   issue;
  logic                   a_vld_r, b_vld_r, c_vld_r;
  logic [1:0]             a_row_r, a_k_r, b_row_r, b_k_r, c_row_r;
  logic [31:0]            v_r;
  logic [3:0][31:0]       prow_r;
  logic [3:0][63:0]       prod_r;
  logic [3:0][ACC_W-1:0]  acc_r;
  logic [ACC_W:0]         diff;
  logic [1:0]             col;

  // Matrix element writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
      proj_r <= '0;
    end else begin
      if (wr_view) begin
        view_r[wr_idx] <= wr_data;
      end
      if (wr_proj) begin
        proj_r[wr_idx[3:2]][wr_idx[1:0]] <= wr_data;
      end
    end
  end

  // Sequencer next state: runs until the last clip row is written out.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (c_vld_r && (c_row_r == 2'd3)) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        busy = 1'b0;
      end
      SEQ_RUN: begin
        busy  = 1'b1;
        issue = !cnt_r[4];
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      cnt_r   <= '0;
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == SEQ_IDLE) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 5'd1;
      end
      a_vld_r <= issue;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r && (b_k_r == 2'd3);
    end
  end

  // Operand fetch, one view element and one projection row per step.
  always_ff @(posedge clk) begin
    if (issue) begin
      v_r     <= view_r[cnt_r[3:0]];
      prow_r  <= proj_r[cnt_r[1:0]];
      a_row_r <= cnt_r[3:2];
      a_k_r   <= cnt_r[1:0];
    end
    b_row_r <= a_row_r;
    b_k_r   <= a_k_r;
    c_row_r <= b_row_r;
    for (int j = 0; j < 4; j++) begin
      prod_r[j] <= 64'($signed(v_r) * $signed(prow_r[j]));
    end
  end

  // Accumulate the four clip elements of the current row.
  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      for (int j = 0; j < 4; j++) begin
        if (b_k_r == 2'd0) begin
          acc_r[j] <= ACC_W'($signed(prod_r[j]));
        end else begin
          acc_r[j] <= acc_r[j] + ACC_W'($signed(prod_r[j]));
        end
      end
    end
  end

  // Plane coefficients with saturation to Q32.32.
  always_comb begin
    diff = '0;
    col  = '0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      col = plane_col(p);
      if (plane_sub(p)) begin
        diff = {acc_r[3][ACC_W-1], acc_r[3]} - {acc_r[col][ACC_W-1], acc_r[col]};
      end else begin
        diff = {acc_r[3][ACC_W-1], acc_r[3]} + {acc_r[col][ACC_W-1], acc_r[col]};
      end
      if ((diff[ACC_W:63] == '0) || (diff[ACC_W:63] == '1)) begin
        coef_data[p] = diff[63:0];
      end else if (diff[ACC_W]) begin
        coef_data[p] = {1'b1, 63'd0};
      end else begin
        coef_data[p] = {1'b0, {63{1'b1}}};
      end
    end
  end

  assign coef_wr.we  = c_vld_r;
  assign coef_wr.idx = c_row_r;

endmodule

// File: src/view_frustum_box_culling.sv
// Each item passes through six cells of three stages and then the output
// register. Throughput: one item per cycle for writes and tests while the
// output is not stalled; an extract item waits for tests in flight, then holds
// the input while the sequencer walks the 16 matrix steps.
// Reset: matrices and plane coefficients clear to zero, pipeline empties.
module view_frustum_box_culling #(
  parameter int COORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [1:0]  in_row,
  input  logic [1:0]  in_col,
  input  logic [31:0] in_value,
  input  logic [31:0] in_x_lo,
  input  logic [31:0] in_y_lo,
  input  logic [31:0] in_z_lo,
  input  logic [31:0] in_x_hi,
  input  logic [31:0] in_y_hi,
  input  logic [31:0] in_z_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_visibility,
  output logic        out_is_test
);
  import fvbc_pkg::*;

  logic                                adv, accept, busy, tests_inflight;
  logic                                is_point, is_box;
  coef_wr_t                            coef_wr;
  logic [NUM_PLANES-1:0][63:0]         coef_data;
  token_t                              tok_in;
  token_t [NUM_PLANES:0]               tok;
  logic [NUM_PLANES-1:0]               cell_busy;
  logic                                out_valid_r;
  logic [1:0]                          out_vis_r;
  logic                                out_test_r;

  // The whole row advances when the output register can take an item.
  assign adv            = !out_valid_r || !out_stall;
  assign tests_inflight = |cell_busy;
  assign in_stall       = !adv || busy ||
                          ((in_opcode == OP_EXTRACT) && tests_inflight);
  assign accept         = in_valid && !in_stall;
  assign is_point       = (in_opcode == OP_POINT);
  assign is_box         = (in_opcode == OP_BOX);

  // Item entering the first cell, coordinates sign-extended from COORD_BITS.
  always_comb begin
    tok_in         = '0;
    tok_in.valid   = accept;
    tok_in.is_test = is_point || is_box;
    tok_in.is_box  = is_box;
    tok_in.lo[0]   = 32'($signed(in_x_lo[COORD_BITS-1:0]));
    tok_in.lo[1]   = 32'($signed(in_y_lo[COORD_BITS-1:0]));
    tok_in.lo[2]   = 32'($signed(in_z_lo[COORD_BITS-1:0]));
    if (is_box) begin
      tok_in.hi[0] = 32'($signed(in_x_hi[COORD_BITS-1:0]));
      tok_in.hi[1] = 32'($signed(in_y_hi[COORD_BITS-1:0]));
      tok_in.hi[2] = 32'($signed(in_z_hi[COORD_BITS-1:0]));
    end else begin
      tok_in.hi    = tok_in.lo;
    end
  end

  assign tok[0] = tok_in;

  // Matrix store and plane extraction.
  fvbc_extract u_extract (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_view   (accept && (in_opcode == OP_WR_VIEW)),
    .wr_proj   (accept && (in_opcode == OP_WR_PROJ)),
    .wr_idx    ({in_row, in_col}),
    .wr_data   (in_value),
    .start     (accept && (in_opcode == OP_EXTRACT)),
    .busy      (busy),
    .coef_wr   (coef_wr),
    .coef_data (coef_data)
  );

  // Row of plane cells; the last plane, column 3 plus column 2, is skipped by box tests.
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    fvbc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .skip_box  (p == NUM_PLANES - 1),
      .coef_wr   (coef_wr),
      .coef_data (coef_data[p]),
      .tok_i     (tok[p]),
      .tok_o     (tok[p+1]),
      .test_busy (cell_busy[p])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_vis_r   <= VIS_NONE;
      out_test_r  <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok[NUM_PLANES].valid;
      out_test_r  <= tok[NUM_PLANES].is_test;
      if (!tok[NUM_PLANES].is_test || tok[NUM_PLANES].culled) begin
        out_vis_r <= VIS_NONE;
      end else if (tok[NUM_PLANES].partial) begin
        out_vis_r <= VIS_PART;
      end else begin
        out_vis_r <= VIS_FULL;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_visibility = out_vis_r;
  assign out_is_test    = out_test_r;

  // Extraction never starts while a test is still reading the planes.
  a_no_extract_over_tests: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !$past(tests_inflight))
    else $error("plane extraction started with tests in flight");

  // No item is taken while the sequencer rewrites the planes.
  a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("input accepted during plane extraction");

  // Coefficients are only written while the sequencer runs.
  a_coef_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    coef_wr.we |-> busy)
    else $error("coefficient write outside extraction");

  // Non-test results always report invisible.
  a_nontest_vis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_test) |-> (out_visibility == VIS_NONE))
    else $error("non-test item reported visibility");

endmodule
